>>> rtl/qrcp_pkg.sv
// qrcp_pkg: shared types and constants of the quantized reciprocal block
// no dependencies; used by every module of the block by scoped names
package qrcp_pkg;

	// quotient bits resolved by the divider row (one per cell)
	localparam int QBITS = 18;
	// magnitude of the zero-point-corrected sample
	localparam int MAG_W = 16;
	// doubled mantissa after the right shift
	localparam int NUM_W = 33;
	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	// request accept edge to result accept edge, in cycles
	localparam int LATENCY = QBITS + 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDE_MODE   = 3'd0,
		REG_IN_ZP       = 3'd1,
		REG_OUT_ZP      = 3'd2,
		REG_SCALE_MULT  = 3'd3,
		REG_SCALE_SHIFT = 3'd4
	} cfg_reg_t;

	// payload handed from cell to cell along the divider row
	typedef struct packed {
		logic [MAG_W-1:0] rem;   // partial remainder, below mag unless ovf is set
		logic [QBITS-1:0] numer; // dividend bits not yet consumed, msb first
		logic [QBITS-1:0] quo;   // quotient bits produced so far
		logic [MAG_W-1:0] mag;   // divisor
		logic             neg;   // corrected sample was negative
		logic             zero;  // corrected sample was zero
		logic             ovf;   // quotient too large, result saturates
	} div_t;

endpackage

>>> rtl/quantized_reciprocal.sv
// quantized_reciprocal: top level of the elementwise quantized reciprocal
// depends on qrcp_pkg, qrcp_front, qrcp_cell, qrcp_back
//
// usage
//   a request is taken at each rising edge with start high and busy low; busy
//   stays low, so a new sample may be offered in every cycle
//   each request yields exactly one result: result, saturated and zero_input
//   are valid for the single cycle in which done is high, in request order
//   pipeline from the request edge to the edge that takes the result
//   (two front stages, one cell per quotient bit in an 18-cell divider row,
//   two back stages); throughput is one request per cycle
//   result = round(scale_mult * 2^-scale_shift / (sample - in_zero_point))
//   + out_zero_point, clamped to the 8-bit or DATA_WIDTH-bit signed range
//   configuration: cfg_we writes cfg_data to register cfg_index, unused indexes
//   ignored; the user must write only while no request is in flight, unenforced
//   reset: arst_n clears the pipeline valid bits and loads scale 1.0, zero
//   points of 0 and wide mode; no results appear until a request arrives
//   the receiver cannot stall, so done is never held off
module quantized_reciprocal #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              start,
	output logic                              busy,
	input  logic [15:0]                       sample,
	// result channel
	output logic                              done,
	output logic [15:0]                       result,
	output logic                              saturated,
	output logic                              zero_input,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [qrcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qrcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration registers
	logic        wide_mode_q;
	logic [15:0] in_zero_point_q;
	logic [15:0] out_zero_point_q;
	logic [31:0] scale_mult_q;
	logic [5:0]  scale_shift_q;

	// divider row: entry 0 comes from the front, entry QBITS goes to the back
	logic           row_vld [qrcp_pkg::QBITS+1];
	qrcp_pkg::div_t row_div [qrcp_pkg::QBITS+1];

	// fully pipelined, never refuses a request
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q      <= 1'b1;
			in_zero_point_q  <= 16'd0;
			out_zero_point_q <= 16'd0;
			scale_mult_q     <= 32'd65536;
			scale_shift_q    <= 6'd16;
		end else if (cfg_we) begin
			unique case (qrcp_pkg::cfg_reg_t'(cfg_index))
				qrcp_pkg::REG_WIDE_MODE: begin
					wide_mode_q <= cfg_data[0];
				end
				qrcp_pkg::REG_IN_ZP: begin
					in_zero_point_q <= cfg_data[15:0];
				end
				qrcp_pkg::REG_OUT_ZP: begin
					out_zero_point_q <= cfg_data[15:0];
				end
				qrcp_pkg::REG_SCALE_MULT: begin
					scale_mult_q <= cfg_data[31:0];
				end
				qrcp_pkg::REG_SCALE_SHIFT: begin
					scale_shift_q <= cfg_data[5:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// zero point removal, scale shift, divisor magnitude and overflow check
	qrcp_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (start & ~busy),
		.sample        (sample),
		.wide_mode     (wide_mode_q),
		.in_zero_point (in_zero_point_q),
		.scale_mult    (scale_mult_q),
		.scale_shift   (scale_shift_q),
		.out_vld       (row_vld[0]),
		.out_div       (row_div[0])
	);

	// one quotient bit per cell, msb first; each cell hands its remainder on
	for (genvar i = 0; i < qrcp_pkg::QBITS; i++) begin : g_cell
		qrcp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (row_vld[i]),
			.in_div  (row_div[i]),
			.out_vld (row_vld[i+1]),
			.out_div (row_div[i+1])
		);
	end

	// rounding, output zero point and clamp
	qrcp_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_vld         (row_vld[qrcp_pkg::QBITS]),
		.in_div         (row_div[qrcp_pkg::QBITS]),
		.wide_mode      (wide_mode_q),
		.out_zero_point (out_zero_point_q),
		.done           (done),
		.result         (result),
		.saturated      (saturated),
		.zero_input     (zero_input)
	);

endmodule

>>> rtl/qrcp_front.sv
// qrcp_front: input stages, zero point removal, scale shift and divider setup
// depends on qrcp_pkg
module qrcp_front #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [15:0]                  sample,
	input  logic                         wide_mode,
	input  logic [15:0]                  in_zero_point,
	input  logic [31:0]                  scale_mult,
	input  logic [5:0]                   scale_shift,
	output logic                         out_vld,
	output qrcp_pkg::div_t               out_div
);

	localparam int XW = 17;

	logic [XW-1:0]                x_wide;
	logic [XW-1:0]                x_narrow;
	logic [XW-1:0]                x_sel;
	logic [XW-1:0]                d_next;
	logic [qrcp_pkg::NUM_W-1:0]   num_next;

	logic                         vld_s1;
	logic [XW-1:0]                d_s1;
	logic [qrcp_pkg::NUM_W-1:0]   num_s1;

	logic [XW-1:0]                mag_full;
	qrcp_pkg::div_t               div_next;

	assign x_wide   = {{(XW-DATA_WIDTH){sample[DATA_WIDTH-1]}}, sample[DATA_WIDTH-1:0]};
	assign x_narrow = {{(XW-8){sample[7]}}, sample[7:0]};
	assign x_sel    = wide_mode ? x_wide : x_narrow;
	assign d_next   = x_sel - {in_zero_point[15], in_zero_point};
	// doubled mantissa over 2^shift; shifts past the top give zero
	assign num_next = {scale_mult, 1'b0} >> scale_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		d_s1   <= d_next;
		num_s1 <= num_next;
	end

	assign mag_full = d_s1[XW-1] ? (~d_s1 + XW'(1)) : d_s1;

	always_comb begin
		div_next.mag   = mag_full[qrcp_pkg::MAG_W-1:0];
		div_next.neg   = d_s1[XW-1];
		div_next.zero  = (d_s1 == '0);
		// top dividend bits at or above the divisor mean a quotient past the row
		div_next.ovf   = ({1'b0, num_s1[qrcp_pkg::NUM_W-1:qrcp_pkg::QBITS]}
			>= mag_full[qrcp_pkg::MAG_W-1:0]);
		div_next.rem   = {1'b0, num_s1[qrcp_pkg::NUM_W-1:qrcp_pkg::QBITS]};
		div_next.numer = num_s1[qrcp_pkg::QBITS-1:0];
		div_next.quo   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_div <= div_next;
	end

endmodule

>>> rtl/qrcp_cell.sv
// qrcp_cell: one restoring division step, resolves one quotient bit per cycle
// depends on qrcp_pkg
module qrcp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  qrcp_pkg::div_t in_div,
	output logic           out_vld,
	output qrcp_pkg::div_t out_div
);

	logic [qrcp_pkg::MAG_W:0] rem_sh;
	logic [qrcp_pkg::MAG_W:0] diff;
	logic                     ge;
	qrcp_pkg::div_t           div_next;

	assign rem_sh = {in_div.rem, in_div.numer[qrcp_pkg::QBITS-1]};
	assign diff   = rem_sh - {1'b0, in_div.mag};
	assign ge     = (rem_sh >= {1'b0, in_div.mag});

	always_comb begin
		div_next       = in_div;
		div_next.rem   = ge ? diff[qrcp_pkg::MAG_W-1:0] : rem_sh[qrcp_pkg::MAG_W-1:0];
		div_next.numer = {in_div.numer[qrcp_pkg::QBITS-2:0], 1'b0};
		div_next.quo   = {in_div.quo[qrcp_pkg::QBITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_div <= div_next;
	end

endmodule

>>> rtl/qrcp_back.sv
// qrcp_back: rounding, sign, output zero point and clamp to the selected range
// depends on qrcp_pkg
module qrcp_back #(
	parameter int DATA_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  qrcp_pkg::div_t in_div,
	input  logic           wide_mode,
	input  logic [15:0]    out_zero_point,
	output logic           done,
	output logic [15:0]    result,
	output logic           saturated,
	output logic           zero_input
);

	localparam int QW = qrcp_pkg::QBITS;
	localparam logic signed [19:0] POS_WIDE   = 20'((1 << (DATA_WIDTH - 1)) - 1);
	localparam logic signed [19:0] POS_NARROW = 20'sd127;

	logic [QW:0]          q_sum;
	logic [QW-1:0]        q_mag;
	logic [QW:0]          sval_next;

	logic                 vld_s1;
	logic [QW:0]          sval_s1;
	logic                 neg_s1;
	logic                 zero_s1;
	logic                 ovf_s1;

	logic signed [19:0]   val;
	logic signed [19:0]   pos_lim;
	logic signed [19:0]   neg_lim;
	logic signed [19:0]   val_sel;
	logic                 sat_sel;

	// halve the doubled quotient, rounding half away from zero
	assign q_sum     = {1'b0, in_div.quo} + (QW+1)'(1);
	assign q_mag     = q_sum[QW:1];
	assign sval_next = in_div.neg ? (~{1'b0, q_mag} + (QW+1)'(1)) : {1'b0, q_mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		sval_s1 <= sval_next;
		neg_s1  <= in_div.neg;
		zero_s1 <= in_div.zero;
		ovf_s1  <= in_div.ovf;
	end

	assign val     = $signed({{(20-QW-1){sval_s1[QW]}}, sval_s1})
		+ $signed({{4{out_zero_point[15]}}, out_zero_point});
	assign pos_lim = wide_mode ? POS_WIDE : POS_NARROW;
	assign neg_lim = -pos_lim - 20'sd1;

	always_comb begin
		val_sel = val;
		sat_sel = 1'b0;
		priority if (zero_s1) begin
			val_sel = pos_lim;
			sat_sel = 1'b1;
		end else if (ovf_s1) begin
			val_sel = neg_s1 ? neg_lim : pos_lim;
			sat_sel = 1'b1;
		end else if (val > pos_lim) begin
			val_sel = pos_lim;
			sat_sel = 1'b1;
		end else if (val < neg_lim) begin
			val_sel = neg_lim;
			sat_sel = 1'b1;
		end else begin
			val_sel = val;
			sat_sel = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		result     <= val_sel[15:0];
		saturated  <= sat_sel;
		zero_input <= zero_s1;
	end

endmodule

>>> rtl/qrcp_checker.sv
// qrcp_checker: port-level assertions for quantized_reciprocal, bound to the top
// depends on qrcp_pkg
module qrcp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [15:0] result,
	input  logic        saturated,
	input  logic        zero_input
);

	// every request produces its result after the fixed latency
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(qrcp_pkg::LATENCY) done)
	else $error("request without result after pipeline latency");

	// no result without a request the fixed latency earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, qrcp_pkg::LATENCY))
	else $error("result without matching request");

	// a zero divisor always reports saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_input) |-> saturated)
	else $error("zero input without saturation");

	// a zero divisor gives the positive limit, never a negative value
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_input) |-> !result[15])
	else $error("zero input with negative result");

endmodule

bind quantized_reciprocal qrcp_checker u_qrcp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.result     (result),
	.saturated  (saturated),
	.zero_input (zero_input)
);

>>> sim/quantized_reciprocal_test.sv
`timescale 1ns / 1ps
// quantized_reciprocal_test: self-checking bench for the quantized reciprocal block
// depends on qrcp_pkg and quantized_reciprocal; computes each expected result locally
module quantized_reciprocal_test;

	localparam int DATA_W = 16;
	localparam int HALF_PERIOD = 6;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_REQS = 75;
	localparam int GAP_PCT = 27;
	// indexes past the register list, writes there must be ignored
	localparam logic [qrcp_pkg::CFG_IDX_W-1:0] IDX_UNUSED_FIRST =
		qrcp_pkg::REG_SCALE_SHIFT + 3'd1;
	localparam logic [qrcp_pkg::CFG_IDX_W-1:0] IDX_UNUSED_LAST = '1;

	// what the driver does next: offer a sample, write a register, or hold
	// until every request in flight has come back
	typedef enum logic [1:0] {
		REQ_SAMPLE,
		REQ_WRITE,
		REQ_DRAIN
	} req_kind_t;

	typedef struct {
		req_kind_t                       kind;
		logic [15:0]                     smp;
		logic [qrcp_pkg::CFG_IDX_W-1:0]  idx;
		logic [qrcp_pkg::CFG_DATA_W-1:0] data;
		int unsigned                     gap_pct;
	} req_t;

	typedef struct packed {
		logic [15:0] value;
		logic        sat;
		logic        zero;
	} recip_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic [15:0]                     sample = '0;
	logic                            cfg_we = 1'b0;
	logic [qrcp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [qrcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            busy;
	logic                            done;
	logic [15:0]                     result;
	logic                            saturated;
	logic                            zero_input;

	// bench copy of the configuration, tracked from the write port
	logic                  cur_wide = 1'b1;
	logic [15:0]           cur_in_zp = '0;
	logic [15:0]           cur_out_zp = '0;
	logic [31:0]           cur_mult = 32'd65536;
	logic [5:0]            cur_shift = 6'd16;

	req_t                  pending_reqs[$];
	recip_t                expected_recips[$];
	int                    in_flight = 0;
	int                    errors = 0;
	int unsigned           gap_pct = GAP_PCT;

	quantized_reciprocal #(
		.DATA_WIDTH(DATA_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.result(result),
		.saturated(saturated),
		.zero_input(zero_input),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// rounded, offset and clamped reciprocal of one sample under the current setting
	function automatic recip_t predict_recip(logic [15:0] smp);
		longint          pos_lim;
		longint          neg_lim;
		longint          x;
		longint          d;
		longint          val;
		longint unsigned mag;
		longint unsigned den;
		longint unsigned q;
		recip_t          r;
		pos_lim = cur_wide ? (longint'(1) <<< (DATA_W - 1)) - 1 : 127;
		neg_lim = -pos_lim - 1;
		// narrow mode only looks at the low byte, the upper bits are don't-care
		x = cur_wide ? longint'($signed(smp[DATA_W-1:0])) : longint'($signed(smp[7:0]));
		d = x - longint'($signed(cur_in_zp));
		r.sat = 1'b0;
		r.zero = (d == 0);
		if (d == 0) begin
			// division by zero reports the positive limit
			val = pos_lim;
			r.sat = 1'b1;
		end else begin
			mag = (d < 0) ? -d : d;
			q = 0;
			// from 33 fractional bits on the quotient is below one half
			if (cur_shift < 33) begin
				den = mag << cur_shift;
				// half away from zero: round the magnitude, then apply the sign
				q = ((64'(cur_mult) << 1) + den) / (den << 1);
			end
			val = (d < 0) ? -longint'(q) : longint'(q);
			val += longint'($signed(cur_out_zp));
			if (val > pos_lim) begin
				val = pos_lim;
				r.sat = 1'b1;
			end else if (val < neg_lim) begin
				val = neg_lim;
				r.sat = 1'b1;
			end
		end
		r.value = val[15:0];
		return r;
	endfunction

	// driver: presents the head of the pending list, holds a sample while busy
	always @(posedge clk or negedge arst_n) begin : drive_reqs
		logic                            n_start;
		logic [15:0]                     n_sample;
		logic                            n_we;
		logic [qrcp_pkg::CFG_IDX_W-1:0]  n_index;
		logic [qrcp_pkg::CFG_DATA_W-1:0] n_data;
		req_t                            head;
		if (!arst_n) begin
			start <= 1'b0;
			sample <= '0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			n_start = start;
			n_sample = sample;
			n_we = 1'b0;
			n_index = cfg_index;
			n_data = cfg_data;
			if (!(start && busy)) begin
				n_start = 1'b0;
				if (pending_reqs.size() != 0) begin
					head = pending_reqs[0];
					case (head.kind)
						REQ_SAMPLE: begin
							// random gap before offering the next sample
							if ($urandom_range(99) >= head.gap_pct) begin
								n_start = 1'b1;
								n_sample = head.smp;
								void'(pending_reqs.pop_front());
							end
						end
						REQ_WRITE: begin
							// registers change only with nothing in flight; start
							// high now means a request is taken at this very edge
							if (!start && in_flight == 0) begin
								n_we = 1'b1;
								n_index = head.idx;
								n_data = head.data;
								void'(pending_reqs.pop_front());
							end
						end
						default: begin
							if (!start && in_flight == 0)
								void'(pending_reqs.pop_front());
						end
					endcase
				end
			end
			start <= n_start;
			sample <= n_sample;
			cfg_we <= n_we;
			cfg_index <= n_index;
			cfg_data <= n_data;
		end
	end

	// monitor: follows register writes, predicts each taken request and
	// checks every done strobe against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_recips
		recip_t want;
		recip_t got;
		if (!arst_n) begin
			in_flight <= 0;
			cur_wide = 1'b1;
			cur_in_zp = '0;
			cur_out_zp = '0;
			cur_mult = 32'd65536;
			cur_shift = 6'd16;
		end else begin
			if (cfg_we) begin
				// only the register's own width is kept
				case (cfg_index)
					qrcp_pkg::REG_WIDE_MODE:   cur_wide = cfg_data[0];
					qrcp_pkg::REG_IN_ZP:       cur_in_zp = cfg_data[15:0];
					qrcp_pkg::REG_OUT_ZP:      cur_out_zp = cfg_data[15:0];
					qrcp_pkg::REG_SCALE_MULT:  cur_mult = cfg_data[31:0];
					qrcp_pkg::REG_SCALE_SHIFT: cur_shift = cfg_data[5:0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_recips.push_back(predict_recip(sample));
			if (done) begin
				got = {result, saturated, zero_input};
				if (expected_recips.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none actual %0d",
						$time, $signed(got.value));
				end else begin
					want = expected_recips.pop_front();
					if (got.value !== want.value) begin
						errors++;
						$display("%0t: result mismatch, expected %0d actual %0d",
							$time, $signed(want.value), $signed(got.value));
					end
					if (got.sat !== want.sat) begin
						errors++;
						$display("%0t: saturated mismatch, expected %0b actual %0b",
							$time, want.sat, got.sat);
					end
					if (got.zero !== want.zero) begin
						errors++;
						$display("%0t: zero_input mismatch, expected %0b actual %0b",
							$time, want.zero, got.zero);
					end
				end
			end
			in_flight <= in_flight + int'(start && !busy) - int'(done);
		end
	end

	task automatic queue_sample(logic [15:0] smp);
		req_t r;
		r.kind = REQ_SAMPLE;
		r.smp = smp;
		r.idx = '0;
		r.data = '0;
		r.gap_pct = gap_pct;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_write(logic [qrcp_pkg::CFG_IDX_W-1:0] idx,
		logic [qrcp_pkg::CFG_DATA_W-1:0] data);
		req_t r;
		r.kind = REQ_WRITE;
		r.smp = '0;
		r.idx = idx;
		r.data = data;
		r.gap_pct = 0;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_drain();
		req_t r;
		r.kind = REQ_DRAIN;
		r.smp = '0;
		r.idx = '0;
		r.data = '0;
		r.gap_pct = 0;
		pending_reqs.push_back(r);
	endtask

	// full setting, with junk above the width of each register narrower than cfg_data
	task automatic queue_setting(logic wide, logic [15:0] in_zp, logic [15:0] out_zp,
		logic [31:0] mult, logic [5:0] shift);
		queue_write(qrcp_pkg::REG_WIDE_MODE, {31'($urandom), wide});
		queue_write(qrcp_pkg::REG_IN_ZP, {16'($urandom), in_zp});
		queue_write(qrcp_pkg::REG_OUT_ZP, {16'($urandom), out_zp});
		queue_write(qrcp_pkg::REG_SCALE_MULT, mult);
		queue_write(qrcp_pkg::REG_SCALE_SHIFT, {26'($urandom), shift});
	endtask

	// stimulus and end of run
	initial begin : stimulus
		logic                 wide;
		logic [15:0]          in_zp;
		logic [15:0]          out_zp;
		logic [31:0]          mult;
		logic [5:0]           shift;
		logic [15:0]          smp;
		logic [7:0]           offs;
		int                   guard;
		arst_n = 1'b0;

		// reset setting is wide mode, scale 1.0, zero points 0
		queue_sample(16'h0000);   // divide by zero
		queue_sample(16'h0001);
		queue_sample(16'hFFFF);
		queue_sample(16'h0002);   // exact half rounds up
		queue_sample(16'hFFFE);   // minus one half rounds down
		queue_sample(16'h0003);
		queue_sample(16'h7FFF);
		queue_sample(16'h8000);

		// largest scale, widest zero point spread
		queue_setting(1'b1, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 6'd0);
		queue_sample(16'h7FFF);
		queue_sample(16'h8000);   // equals the input zero point
		queue_sample(16'h0000);

		// narrow mode: upper byte ignored, 8-bit limits
		queue_setting(1'b0, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 6'd20);
		for (int i = IDX_UNUSED_FIRST; i <= IDX_UNUSED_LAST; i++)
			queue_write(i[qrcp_pkg::CFG_IDX_W-1:0], $urandom);
		queue_sample(16'hFF80);
		queue_sample(16'h7F7F);
		queue_sample(16'h0100);   // low byte zero

		// zero mantissa with the most negative offset, clamped to -128; a sample at the zero point gives 127
		queue_setting(1'b0, 16'hFF80, 16'h8000, 32'h0000_0000, 6'd63);
		queue_sample(16'h0000);
		queue_sample(16'hAB80);

		// quotient below one half
		queue_setting(1'b1, 16'h7FFF, 16'h0000, 32'h8000_0000, 6'd33);
		queue_sample(16'h8000);
		queue_sample(16'h7FFE);
		// exactly one half at 32 fractional bits
		queue_write(qrcp_pkg::REG_SCALE_SHIFT, 32'd32);
		queue_sample(16'h7FFE);
		queue_sample(16'h7FFD);

		// zero mantissa, offset at the positive wide limit
		queue_setting(1'b1, 16'h0000, 16'h7FFF, 32'h0000_0000, 6'd5);
		queue_sample(16'h1234);
		queue_drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			// one phase with no gaps at all
			gap_pct = (ph == 5) ? 0 : GAP_PCT;
			wide = 1'($urandom_range(1));
			case ($urandom_range(5))
				0: in_zp = 16'h8000;
				1: in_zp = 16'h7FFF;
				2: in_zp = 16'($urandom);
				default: in_zp = wide ? 16'($urandom) : 16'($urandom_range(255)) - 16'd128;
			endcase
			case ($urandom_range(5))
				0: out_zp = 16'h8000;
				1: out_zp = 16'h7FFF;
				2: out_zp = 16'h0000;
				3: out_zp = 16'($urandom);
				default: out_zp = 16'($urandom_range(400)) - 16'd200;
			endcase
			case ($urandom_range(3))
				0: begin
					mult = $urandom;
					shift = 6'($urandom_range(63));
				end
				1: begin
					mult = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0000_0000;
					shift = ($urandom_range(1)) ? 6'd63 : 6'd0;
				end
				default: begin
					// scales that land inside the output range most of the time
					mult = $urandom >> $urandom_range(31);
					shift = 6'($urandom_range(36, 12));
				end
			endcase
			queue_setting(wide, in_zp, out_zp, mult, shift);
			for (int i = 0; i < PHASE_REQS; i++) begin
				offs = 8'($urandom_range(32)) - 8'd16;
				case ($urandom_range(7))
					0: smp = wide ? in_zp : {8'($urandom), in_zp[7:0]};
					1, 2, 3: smp = wide ? in_zp + {{8{offs[7]}}, offs}
						: {8'($urandom), in_zp[7:0] + offs};
					default: smp = 16'($urandom);
				endcase
				queue_sample(smp);
				// now and then let everything come back before going on
				if (i == PHASE_REQS / 2 && $urandom_range(2) == 0)
					queue_drain();
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || start)
			@(negedge clk);
		guard = 0;
		while (expected_recips.size() != 0 && guard < 4 * qrcp_pkg::LATENCY) begin
			guard++;
			@(negedge clk);
		end
		// catch any stray strobe after the last expected result
		repeat (qrcp_pkg::LATENCY + 4) @(negedge clk);
		if (expected_recips.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_recips.size());
		end
		if (errors == 0 && expected_recips.size() == 0) begin
			$display("quantized_reciprocal verification clean");
		end else begin
			$display("quantized_reciprocal verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("quantized_reciprocal verification failed");
		$finish;
	end

endmodule
